>>> design/tbvn_pkg.sv
// Shared types and constants for the tileable B-spline value noise block.
// No dependencies; imported by tbvn_front, tbvn_back and the top level.
`timescale 1ns / 1ps
package tbvn_pkg;

   localparam int STORE_DEPTH = 4096;
   localparam int STORE_AW    = 12;
   localparam int REQ_DATA_W  = 80;
   localparam int RSP_DATA_W  = 16;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   localparam logic REG_SAMPLE_RANGE = 1'b0;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_EVAL = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [11:0] table_index;
      logic [15:0] table_value;
      logic [23:0] x_coord;
      logic [23:0] y_coord;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SQ,
      ST_IDX,
      ST_READ,
      ST_DRAIN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0] count;
   } front_stat_type;

   typedef struct packed {
      logic idle;
      logic pop;
   } back_stat_type;

endpackage

>>> design/tbvn_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module tbvn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule

>>> design/tbvn_front.sv
// Front end: accepts request transactions, decodes kind, two-entry queue.
// Depends on tbvn_pkg.
`timescale 1ns / 1ps
module tbvn_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // table_index[11:0], table_value[27:12], x_coord[51:28], y_coord[75:52]
   input  logic [tbvn_pkg::REQ_DATA_W-1:0]       req_tdata,
   // kind[0]
   input  logic                                  req_tuser,
   output logic                                  cmd_valid,
   input  logic                                  cmd_ready,
   output tbvn_pkg::cmd_type                     cmd,
   output tbvn_pkg::front_stat_type              stat
);
   import tbvn_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    incoming;
   logic       push, pop;

   always_comb begin
      incoming.kind        = req_tuser ? KIND_EVAL : KIND_LOAD;
      incoming.table_index = req_tdata[11:0];
      incoming.table_value = req_tdata[27:12];
      incoming.x_coord     = req_tdata[51:28];
      incoming.y_coord     = req_tdata[75:52];
      req_tready = (count_ff != 2'd2);
      cmd_valid  = (count_ff != 2'd0);
      cmd        = q_ff[rd_ptr_ff];
      push       = req_tvalid && req_tready;
      pop        = cmd_valid && cmd_ready;
      wr_ptr_in  = wr_ptr_ff ^ push;
      rd_ptr_in  = rd_ptr_ff ^ pop;
      count_in   = count_ff + 2'(push) - 2'(pop);
      stat.count = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= incoming;
      end
   end
endmodule

>>> design/tbvn_back.sv
// Back end: table store, coordinate split, weights, nine-tap blend, result register.
// Depends on tbvn_pkg and tbvn_ram.
`timescale 1ns / 1ps
module tbvn_back #(
   parameter int TABLE_WIDTH = 64,
   parameter int VALUE_BITS  = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  cmd_valid,
   output logic                                  cmd_ready,
   input  tbvn_pkg::cmd_type                     cmd,
   input  logic [15:0]                           sample_range,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [tbvn_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output tbvn_pkg::back_stat_type               stat
);
   import tbvn_pkg::*;

   localparam int F    = VALUE_BITS;
   localparam int SQW  = 2 * F + 2;
   localparam int IW   = $clog2(TABLE_WIDTH);
   localparam int PW   = 2 * F;
   localparam int PRW  = 2 * F + 16;
   localparam int ACW  = 2 * F + 17;
   localparam int LSH  = (F >= 16) ? F - 16 : 0;
   localparam int RSH  = (F < 16) ? 16 - F : 0;
   localparam logic [31:0] RECIP =
      32'(((64'd1 << 32) + 64'(TABLE_WIDTH - 1)) / 64'(TABLE_WIDTH));
   localparam logic [16:0] TW17 = 17'(TABLE_WIDTH);

   function automatic logic [F-1:0] rescale(input logic [15:0] f16);
      logic [F+15:0] t;
      t = {{F{1'b0}}, f16} << LSH;
      rescale = F'(t >> RSH);
   endfunction

   function automatic logic [3*F-1:0] weights(input logic [SQW-1:0] dd,
                                              input logic [SQW-1:0] uu);
      logic [SQW-1:0] mid;
      mid = (SQW'(1) << (2 * F + 1)) - dd - uu;
      weights = {F'(uu >> (F + 1)), F'(mid >> (F + 1)), F'(dd >> (F + 1))};
   endfunction

   function automatic logic [3*IW-1:0] neigh(input logic [15:0] c0,
                                             input logic [15:0] q,
                                             input logic [15:0] rng);
      logic [16:0] r, c1, c2, m, m1, m2, a0, a1, a2;
      r  = {1'b0, rng};
      c1 = {1'b0, c0} + 17'd1;
      c2 = {1'b0, c0} + 17'd2;
      m  = {1'b0, c0} - 17'(32'(q) * 32'(TABLE_WIDTH));
      m1 = m + 17'd1;
      m2 = m + 17'd2;
      if (r > TW17) begin
         a0 = m;
         a1 = (c1 == r) ? 17'd0 : ((m1 == TW17) ? 17'd0 : m1);
         a2 = (c2 >= r) ? (c2 - r) : ((m2 >= TW17) ? (m2 - TW17) : m2);
      end else begin
         a0 = {1'b0, c0};
         a1 = (c1 == r) ? 17'd0 : c1;
         a2 = (c2 >= r) ? (c2 - r) : c2;
      end
      neigh = {IW'(a2), IW'(a1), IW'(a0)};
   endfunction

   state_type       state_ff, state_in;
   logic [15:0]     x16_ff, x16_in, y16_ff, y16_in;
   logic [31:0]     px_ff, px_in, py_ff, py_in;
   logic [SQW-1:0]  ddx_ff, ddx_in, uux_ff, uux_in, ddy_ff, ddy_in, uuy_ff, uuy_in;
   logic [15:0]     qx_ff, qx_in, qy_ff, qy_in;
   logic [F-1:0]    wx_ff [3];
   logic [F-1:0]    wy_ff [3];
   logic [IW-1:0]   ix_ff [3];
   logic [IW-1:0]   iy_ff [3];
   logic [3*F-1:0]  wxv, wyv;
   logic [3*IW-1:0] ixv, iyv;
   logic            load_w;
   logic [1:0]      col_ff, col_in, row_ff, row_in;
   logic            s1_ff, s1_in, s2_ff;
   logic [PW-1:0]   pw_ff, pw_in;
   logic [PRW-1:0]  prod_ff;
   logic [ACW-1:0]  acc_ff, acc_in, rounded;
   logic [ACW-2*F-1:0] res;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [15:0]     rsp_data_ff, rsp_data_in;
   logic            ram_we;
   logic [STORE_AW-1:0] ram_addr;
   logic [15:0]     ram_rdata;
   logic [F:0]      dx, dy;
   logic [F-1:0]    ux, uy;

   tbvn_ram #(
      .WIDTH(16),
      .DEPTH(STORE_DEPTH)
   ) u_table (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(cmd.table_value),
      .rdata(ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      x16_in       = x16_ff;
      y16_in       = y16_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      ddx_in       = ddx_ff;
      uux_in       = uux_ff;
      ddy_in       = ddy_ff;
      uuy_in       = uuy_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      load_w       = 1'b0;
      col_in       = col_ff;
      row_in       = row_ff;
      s1_in        = 1'b0;
      pw_in        = pw_ff;
      acc_in       = s2_ff ? acc_ff + ACW'(prod_ff) : acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_addr     = cmd.table_index;
      cmd_ready    = 1'b0;

      ux  = rescale(px_ff[15:0]);
      uy  = rescale(py_ff[15:0]);
      dx  = {1'b1, {F{1'b0}}} - {1'b0, ux};
      dy  = {1'b1, {F{1'b0}}} - {1'b0, uy};
      wxv = weights(ddx_ff, uux_ff);
      wyv = weights(ddy_ff, uuy_ff);
      ixv = neigh(px_ff[31:16], qx_ff, sample_range);
      iyv = neigh(py_ff[31:16], qy_ff, sample_range);

      rounded = acc_ff + (ACW'(1) << (2 * F - 1));
      res     = rounded[ACW-1:2*F];

      unique case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               if (cmd.kind == KIND_LOAD) begin
                  ram_we = 1'b1;
               end else begin
                  x16_in = cmd.x_coord[15:0];
                  y16_in = cmd.y_coord[15:0];
                  acc_in = '0;
                  state_in = (sample_range == 16'd0) ? ST_OUT : ST_MUL;
               end
            end
         end
         ST_MUL: begin
            px_in    = 32'(x16_ff) * 32'(sample_range);
            py_in    = 32'(y16_ff) * 32'(sample_range);
            state_in = ST_SQ;
         end
         ST_SQ: begin
            ddx_in   = SQW'(dx) * SQW'(dx);
            uux_in   = SQW'(ux) * SQW'(ux);
            ddy_in   = SQW'(dy) * SQW'(dy);
            uuy_in   = SQW'(uy) * SQW'(uy);
            qx_in    = 16'((48'(px_ff[31:16]) * 48'(RECIP)) >> 32);
            qy_in    = 16'((48'(py_ff[31:16]) * 48'(RECIP)) >> 32);
            state_in = ST_IDX;
         end
         ST_IDX: begin
            load_w   = 1'b1;
            col_in   = 2'd0;
            row_in   = 2'd0;
            acc_in   = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            ram_addr = STORE_AW'(17'(iy_ff[row_ff]) * TW17 + 17'(ix_ff[col_ff]));
            pw_in    = PW'(wx_ff[col_ff]) * PW'(wy_ff[row_ff]);
            s1_in    = 1'b1;
            if (col_ff == 2'd2) begin
               col_in = 2'd0;
               row_in = row_ff + 2'd1;
               if (row_ff == 2'd2) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               col_in = col_ff + 2'd1;
            end
         end
         ST_DRAIN: begin
            if (!s1_ff && !s2_ff) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = (res > (ACW-2*F)'(16'hFFFF)) ? 16'hFFFF : 16'(res);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = rsp_data_ff;
      stat.idle  = (state_ff == ST_IDLE);
      stat.pop   = cmd_valid && cmd_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_ff        <= s1_in;
         s2_ff        <= s1_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
      x16_ff      <= x16_in;
      y16_ff      <= y16_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      ddx_ff      <= ddx_in;
      uux_ff      <= uux_in;
      ddy_ff      <= ddy_in;
      uuy_ff      <= uuy_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      pw_ff       <= pw_in;
      prod_ff     <= PRW'(pw_ff) * PRW'(ram_rdata);
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      if (load_w) begin
         for (int k = 0; k < 3; k++) begin
            wx_ff[k] <= wxv[k*F +: F];
            wy_ff[k] <= wyv[k*F +: F];
            ix_ff[k] <= ixv[k*IW +: IW];
            iy_ff[k] <= iyv[k*IW +: IW];
         end
      end
   end
endmodule

>>> design/tileable_bspline_value_noise_2d_top.sv
// Top level of the tileable B-spline value noise block: CSR port, front, back.
// Depends on tbvn_pkg, tbvn_front, tbvn_back, tbvn_ram.
//
//   channel  | ports                     | carries
//   req      | req_tvalid/tready/tdata/tuser | load entry or evaluate point
//   rsp      | rsp_tvalid/tready/tdata   | noise_value
//   csr      | csr_p*                    | sample_range at address 0
//
// A load transaction writes the table while the back end is idle; an evaluate
// passes split, weight and blend pipeline stages and nine table reads through
// the single port of the 4096-entry store. Range zero goes straight to output.
// Reset clears control state and sample_range; the table is not cleared.
// A two-entry queue lets requests arrive while the back end works or the
// result register waits on rsp_tready.
`timescale 1ns / 1ps
module tileable_bspline_value_noise_2d_top #(
   parameter int TABLE_WIDTH = 64,
   parameter int VALUE_BITS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // table_index[11:0], table_value[27:12], x_coord[51:28], y_coord[75:52]
   input  logic [tbvn_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind[0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // noise_value[15:0]
   output logic [tbvn_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tbvn_pkg::CSR_AW-1:0]       csr_paddr,
   input  logic [tbvn_pkg::CSR_DW-1:0]       csr_pwdata,
   output logic [tbvn_pkg::CSR_DW-1:0]       csr_prdata,
   output logic                              csr_pready
);
   import tbvn_pkg::*;

   logic           [15:0] range_ff, range_in;
   logic           cmd_valid, cmd_ready;
   cmd_type        cmd;
   front_stat_type front_stat;
   back_stat_type  back_stat;

   always_comb begin
      csr_pready = 1'b1;
      range_in   = range_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          csr_paddr[2] == REG_SAMPLE_RANGE) begin
         range_in = csr_pwdata[15:0];
      end
      csr_prdata = (csr_paddr[2] == REG_SAMPLE_RANGE) ? CSR_DW'(range_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= 16'd0;
      end else begin
         range_ff <= range_in;
      end
   end

   tbvn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .stat      (front_stat)
   );

   tbvn_back #(
      .TABLE_WIDTH(TABLE_WIDTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd),
      .sample_range(range_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .stat        (back_stat)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      front_stat.count <= 2'd2)
      else $error("queue count overflow");

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> front_stat.count == 2'd2)
      else $error("request stalled with queue space");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      back_stat.pop |-> back_stat.idle)
      else $error("back end took a transaction while busy");

   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_tvalid) |-> $past(rsp_tready))
      else $error("result dropped before it was taken");
endmodule
